@@ rtl/core/bdg_pkg.sv @@
`default_nettype none
package bdg_pkg;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned BtnIdxW    = $clog2(NumButtons);
  localparam int unsigned CntBits    = 16;
  localparam int unsigned TickW      = 16;
  localparam int unsigned ActW       = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam logic [31:0] CntMax     = 32'hFFFF_FFFF >> (32 - CntBits);

  typedef enum logic [ActW-1:0] {
    ActPlayPause    = 3'd0,
    ActVolUp        = 3'd1,
    ActVolDown      = 3'd2,
    ActNext         = 3'd3,
    ActPrev         = 3'd4,
    ActPowerOff     = 3'd5,
    ActChannelCycle = 3'd6
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce    = 3'd0,
    CfgRepeatDelay = 3'd1,
    CfgRepeatIntvl = 3'd2,
    CfgLongPress   = 3'd3,
    CfgDoubleClick = 3'd4,
    CfgDcEnable    = 3'd5,
    CfgPresentMask = 3'd6,
    CfgRepeatMask  = 3'd7
  } cfg_idx_e;

  localparam logic [TickW-1:0]      RstDebounce    = TickW'(50);
  localparam logic [TickW-1:0]      RstRepeatDelay = TickW'(500);
  localparam logic [TickW-1:0]      RstRepeatIntvl = TickW'(200);
  localparam logic [TickW-1:0]      RstLongPress   = TickW'(3000);
  localparam logic [TickW-1:0]      RstDoubleClick = TickW'(350);
  localparam logic [NumButtons-1:0] RstPresentMask = '1;
  localparam logic [NumButtons-1:0] RstRepeatMask  = NumButtons'(6);

  // All actions that one tick produces, one slot per button.
  typedef struct packed {
    logic [NumButtons-1:0]           valid;
    logic [NumButtons-1:0][ActW-1:0] act;
  } bundle_t;

  // A countdown loaded from zero behaves as one; oversized values saturate.
  function automatic logic [CntBits-1:0] load_count(input logic [TickW-1:0] v);
    if (v == '0) begin
      return CntBits'(1);
    end
    if (32'(v) > CntMax) begin
      return '1;
    end
    return CntBits'(v);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/bdg_front.sv @@
`default_nettype none
module bdg_front import bdg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                tick_i,
  input  wire logic [NumButtons-1:0] raw_levels_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [TickW-1:0]    cfg_data_i,
  output bundle_t                  bundle_o,
  output logic                     bundle_valid_o
);

  logic [TickW-1:0]      deb_q, rdel_q, rint_q, long_q, dct_q;
  logic                  dce_q;
  logic [NumButtons-1:0] present_q, rmask_q;

  logic [NumButtons-1:0] prev_q, prev_d, pressed_q, pressed_d;
  logic [NumButtons-1:0] settle_run_q, settle_run_d, rep_run_q, rep_run_d;
  logic [CntBits-1:0]    settle_cnt_q [NumButtons];
  logic [CntBits-1:0]    settle_cnt_d [NumButtons];
  logic [CntBits-1:0]    rep_cnt_q [NumButtons];
  logic [CntBits-1:0]    rep_cnt_d [NumButtons];
  logic [CntBits-1:0]    hold_cnt_q, hold_cnt_d, win_cnt_q, win_cnt_d;
  logic                  hold_run_q, hold_run_d, win_run_q, win_run_d;
  logic [1:0]            tally_q, tally_d;
  bundle_t               bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= RstDebounce;
      rdel_q    <= RstRepeatDelay;
      rint_q    <= RstRepeatIntvl;
      long_q    <= RstLongPress;
      dct_q     <= RstDoubleClick;
      dce_q     <= 1'b1;
      present_q <= RstPresentMask;
      rmask_q   <= RstRepeatMask;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDebounce:    deb_q     <= cfg_data_i;
        CfgRepeatDelay: rdel_q    <= cfg_data_i;
        CfgRepeatIntvl: rint_q    <= cfg_data_i;
        CfgLongPress:   long_q    <= cfg_data_i;
        CfgDoubleClick: dct_q     <= cfg_data_i;
        CfgDcEnable:    dce_q     <= cfg_data_i[0];
        CfgPresentMask: present_q <= cfg_data_i[NumButtons-1:0];
        CfgRepeatMask:  rmask_q   <= cfg_data_i[NumButtons-1:0];
        default: ;
      endcase
    end
  end

  // One tick: every present button runs its repeat countdown, button zero its
  // long-press and click window, then debounce. Only the first action a
  // button raises in a tick is kept.
  always_comb begin
    logic       emitted;
    logic [ActW-1:0] act;
    logic       level_low;
    prev_d       = prev_q;
    pressed_d    = pressed_q;
    settle_run_d = settle_run_q;
    rep_run_d    = rep_run_q;
    settle_cnt_d = settle_cnt_q;
    rep_cnt_d    = rep_cnt_q;
    hold_cnt_d   = hold_cnt_q;
    hold_run_d   = hold_run_q;
    win_cnt_d    = win_cnt_q;
    win_run_d    = win_run_q;
    tally_d      = tally_q;
    bundle       = '0;
    emitted      = 1'b0;
    act          = '0;
    level_low    = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      emitted = 1'b0;
      act     = '0;
      if (tick_i && present_q[i]) begin
        if (rep_run_d[i]) begin
          if (rep_cnt_d[i] <= CntBits'(1)) begin
            rep_cnt_d[i] = '0;
            rep_run_d[i] = 1'b0;
            if (pressed_d[i]) begin
              emitted      = 1'b1;
              act          = ActW'(i);
              rep_cnt_d[i] = load_count(rint_q);
              rep_run_d[i] = 1'b1;
            end
          end else begin
            rep_cnt_d[i] = rep_cnt_d[i] - CntBits'(1);
          end
        end
        if (i == 0) begin
          if (hold_run_d) begin
            if (hold_cnt_d <= CntBits'(1)) begin
              hold_cnt_d = '0;
              hold_run_d = 1'b0;
              win_run_d  = 1'b0;
              tally_d    = '0;
              if (!emitted) begin
                emitted = 1'b1;
                act     = ActPowerOff;
              end
            end else begin
              hold_cnt_d = hold_cnt_d - CntBits'(1);
            end
          end
          if (win_run_d) begin
            if (win_cnt_d <= CntBits'(1)) begin
              win_cnt_d = '0;
              win_run_d = 1'b0;
              if (tally_d >= 2'd2) begin
                tally_d = '0;
                if (!emitted) begin
                  emitted = 1'b1;
                  act     = ActChannelCycle;
                end
              end else if (tally_d == 2'd1 && !pressed_d[0]) begin
                tally_d = '0;
                if (!emitted) begin
                  emitted = 1'b1;
                  act     = ActPlayPause;
                end
              end
            end else begin
              win_cnt_d = win_cnt_d - CntBits'(1);
            end
          end
        end
        if (raw_levels_i[i] != prev_d[i]) begin
          prev_d[i]       = raw_levels_i[i];
          settle_cnt_d[i] = load_count(deb_q);
          settle_run_d[i] = 1'b1;
        end else if (settle_run_d[i]) begin
          if (settle_cnt_d[i] <= CntBits'(1)) begin
            settle_cnt_d[i] = '0;
            settle_run_d[i] = 1'b0;
            level_low       = !raw_levels_i[i];
            if (level_low && !pressed_d[i]) begin
              pressed_d[i] = 1'b1;
              if (i == 0 && dce_q) begin
                if (tally_d < 2'd2) begin
                  tally_d = tally_d + 2'd1;
                end
                win_cnt_d = load_count(dct_q);
                win_run_d = 1'b1;
              end else if (!emitted) begin
                emitted = 1'b1;
                act     = ActW'(i);
              end
              if (rmask_q[i]) begin
                rep_cnt_d[i] = load_count(rdel_q);
                rep_run_d[i] = 1'b1;
              end
              if (i == 0) begin
                hold_cnt_d = load_count(long_q);
                hold_run_d = 1'b1;
              end
            end else if (!level_low && pressed_d[i]) begin
              pressed_d[i] = 1'b0;
              rep_run_d[i] = 1'b0;
              if (i == 0) begin
                hold_run_d = 1'b0;
                if (dce_q && tally_d == 2'd1 && !win_run_d) begin
                  tally_d = '0;
                  if (!emitted) begin
                    emitted = 1'b1;
                    act     = ActPlayPause;
                  end
                end
              end
            end
          end else begin
            settle_cnt_d[i] = settle_cnt_d[i] - CntBits'(1);
          end
        end
      end
      bundle.valid[i] = emitted;
      bundle.act[i]   = act;
    end
    // Turning click counting off drops any pending click.
    if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CfgDcEnable && !cfg_data_i[0]) begin
      win_run_d = 1'b0;
      tally_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '1;
      pressed_q    <= '0;
      settle_run_q <= '0;
      rep_run_q    <= '0;
      hold_run_q   <= 1'b0;
      win_run_q    <= 1'b0;
      tally_q      <= '0;
      hold_cnt_q   <= '0;
      win_cnt_q    <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        settle_cnt_q[i] <= '0;
        rep_cnt_q[i]    <= '0;
      end
    end else begin
      prev_q       <= prev_d;
      pressed_q    <= pressed_d;
      settle_run_q <= settle_run_d;
      rep_run_q    <= rep_run_d;
      hold_run_q   <= hold_run_d;
      win_run_q    <= win_run_d;
      tally_q      <= tally_d;
      hold_cnt_q   <= hold_cnt_d;
      win_cnt_q    <= win_cnt_d;
      settle_cnt_q <= settle_cnt_d;
      rep_cnt_q    <= rep_cnt_d;
    end
  end

  assign bundle_o       = bundle;
  assign bundle_valid_o = tick_i && (bundle.valid != '0);

endmodule
`default_nettype wire

@@ rtl/core/bdg_queue.sv @@
`default_nettype none
module bdg_queue import bdg_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  bundle_t      data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output bundle_t      data_o
);

  bundle_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bdg_back.sv @@
`default_nettype none
module bdg_back import bdg_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  bundle_t              q_data_i,
  output logic                 q_pop_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output logic [ActW-1:0]      action_o,
  output logic                 last_flag_o
);

  logic [NumButtons-1:0]           cur_mask_q, cur_mask_d;
  logic [NumButtons-1:0][ActW-1:0] cur_acts_q, cur_acts_d;
  logic                            out_valid_q, out_valid_d;
  logic [ActW-1:0]                 out_act_q, out_act_d;
  logic                            out_last_q, out_last_d;

  logic [NumButtons-1:0]           src_mask, rest;
  logic [NumButtons-1:0][ActW-1:0] src_acts;
  logic [BtnIdxW-1:0]              sel;
  logic                            advance, use_queue;

  // Work from the bundle in hand; once it is drained, take the queue head.
  assign use_queue = (cur_mask_q == '0) && !q_empty_i;
  assign src_mask  = use_queue ? q_data_i.valid : cur_mask_q;
  assign src_acts  = use_queue ? q_data_i.act : cur_acts_q;
  assign rest      = src_mask & (src_mask - NumButtons'(1));
  assign advance   = !out_valid_q || pop_i;

  always_comb begin
    sel = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (src_mask[i]) begin
        sel = BtnIdxW'(i);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;
    cur_mask_d  = cur_mask_q;
    cur_acts_d  = cur_acts_q;
    q_pop_o     = 1'b0;
    if (advance) begin
      out_valid_d = (src_mask != '0);
      out_act_d   = src_acts[sel];
      out_last_d  = (rest == '0);
      cur_mask_d  = rest;
      cur_acts_d  = src_acts;
      q_pop_o     = use_queue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_mask_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cur_mask_q  <= cur_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_act_q  <= out_act_d;
    out_last_q <= out_last_d;
    cur_acts_q <= cur_acts_d;
  end

  assign empty_o     = !out_valid_q;
  assign action_o    = out_act_q;
  assign last_flag_o = out_last_q;

endmodule
`default_nettype wire

@@ rtl/core/button_debounce_gesture_detector_unit.sv @@
// Button debounce and gesture detector for five active-low buttons.
// Input queue side: each transfer (push high, full low) is one millisecond
// tick carrying raw_levels_i, bit i for button i, zero meaning pressed.
// Result queue side: while empty is low, action_o and last_flag_o show the
// oldest result; a transfer takes place when pop is high. A tick gives zero
// to five results, ordered by button, the final one with last_flag_o set.
// Ticks that give no result leave nothing on the result side.
// Configuration: a write transfer on cfg_valid_i/cfg_ready_o sets register
// cfg_index_i to cfg_data_i; cfg_ready_o is always high. Write only while idle.
// The first result of a tick is registered in the result queue and then in
// the output register before it is visible. Throughput: one tick per cycle
// is taken while the two-entry result queue has room; results leave at one
// per cycle through the output register while pop is high.
// When pop stays low, full rises once two further ticks with results are
// waiting, and input is held off until a tick is taken from the queue.
// Reset clears all buttons to released with no countdown running and loads
// the default register values; nothing waits on the result side after reset.
`default_nettype none
module button_debounce_gesture_detector_unit import bdg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [NumButtons-1:0] raw_levels_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [ActW-1:0]            action_o,
  output logic                       last_flag_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [TickW-1:0]      cfg_data_i
);

  bundle_t f_bundle, q_data;
  logic    f_valid, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  bdg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (push && !full),
    .raw_levels_i   (raw_levels_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .bundle_o       (f_bundle),
    .bundle_valid_o (f_valid)
  );

  bdg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_bundle),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  bdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .action_o    (action_o),
    .last_flag_o (last_flag_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/bdg_checker.sv @@
`default_nettype none
module bdg_checker import bdg_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  push,
  input wire logic                  full,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [ActW-1:0]       action_o,
  input wire logic                  last_flag_o,
  input wire logic                  cfg_ready_o
);

  // Coming out of reset, nothing is pending and input is open.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("result side not idle after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(action_o) && $stable(last_flag_o)))
    else $error("stalled result changed");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (action_o <= ActChannelCycle))
    else $error("undefined action code");

  // The results of one tick follow each other with no gap.
  a_tick_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_flag_o) |=> !empty)
    else $error("gap inside the results of one tick");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> cfg_ready_o)
    else $error("configuration channel stalled");

endmodule

bind button_debounce_gesture_detector_unit bdg_checker u_bdg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .action_o    (action_o),
  .last_flag_o (last_flag_o),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
